// ===== src/bpe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types, opcode codes and encoding tables for the baseline PIC
// 12-bit instruction encoder and byte packer.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // Opcode selector codes, in the order the front end numbers them
  typedef enum logic [5:0] {
    OP_ADDWF, OP_ANDWF, OP_CLRF, OP_CLRW, OP_COMF, OP_DECF,
    OP_DECFSZ, OP_INCF, OP_INCFSZ, OP_IORWF, OP_MOVF, OP_MOVWF,
    OP_NOP, OP_RLF, OP_RRF, OP_SUBWF, OP_SWAPF, OP_XORWF,
    OP_BCF, OP_BSF, OP_BTFSC, OP_BTFSS, OP_ANDLW, OP_CALL,
    OP_CLRWDT, OP_GOTO, OP_IORLW, OP_MOVLW, OP_OPTION,
    OP_RETLW, OP_SLEEP, OP_TRIS, OP_XORLW
  } op_t;

  // Fixed machine words and prefixes
  localparam logic [11:0] W_CLRF_BASE  = 12'h060;
  localparam logic [11:0] W_CLRW       = 12'h040;
  localparam logic [11:0] W_MOVWF_BASE = 12'h020;
  localparam logic [11:0] W_NOP        = 12'h000;
  localparam logic [11:0] W_CLRWDT     = 12'h004;
  localparam logic [11:0] W_GOTO_BASE  = 12'hA00;
  localparam logic [11:0] W_OPTION     = 12'h002;
  localparam logic [11:0] W_SLEEP      = 12'h003;
  localparam logic [3:0]  BIT_OP_BASE  = 4'h4;

  // Upper opcode bits of the byte-oriented file register operations
  localparam int unsigned NUM_BYTE_OPS = 18;
  localparam logic [3:0] BYTE_OPS [NUM_BYTE_OPS] = '{
    4'h7, 4'h5, 4'h3, 4'h0, 4'h9, 4'h3, 4'hB, 4'hA, 4'hF,
    4'h4, 4'h8, 4'h0, 4'h0, 4'hD, 4'hC, 4'h2, 4'hE, 4'h6
  };

  // Upper nibble of the literal operations, indexed from ANDLW
  localparam int unsigned NUM_LIT_OPS = 11;
  localparam logic [3:0] LIT_OPS [NUM_LIT_OPS] = '{
    4'hE, 4'h9, 4'h0, 4'h0, 4'hD, 4'hC, 4'h0, 4'h8, 4'h0, 4'h0, 4'hF
  };

  // Depth of the output byte buffer: two word bytes and a flush byte
  localparam int unsigned SLOTS = 3;

  // Encoder result passed to the packer
  typedef struct packed {
    logic        ok;    // known opcode, word is appended
    logic [11:0] word;
    logic        warn;  // an operand was wider than its field
  } enc_t;

  // One packed output byte with its flags
  typedef struct packed {
    logic [7:0] data;
    logic       warn;
    logic       last;
  } res_t;

endpackage : bpe_pkg
`default_nettype wire

// ===== src/bpe_encode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_encode
// Forms the 12-bit baseline machine word from an opcode and its operands,
// flagging any operand that does not fit its field.
// ----------------------------------------------------------------------------
module bpe_encode
  import bpe_pkg::*;
(
  input  wire logic [5:0]  mode,
  input  wire logic [15:0] reg_addr,
  input  wire logic [15:0] dest_sel,
  input  wire logic [15:0] bit_index,
  input  wire logic [15:0] literal,
  output enc_t             enc
);

  logic       f5_wide;
  logic       f3_wide;
  logic       d_wide;
  logic       b_wide;
  logic       k8_wide;
  logic       k9_wide;
  logic [1:0] bit_sel;
  logic [3:0] lit_idx;
  logic [4:0] byte_idx;

  // Operand overflow checks
  assign f5_wide = |reg_addr[15:5];
  assign f3_wide = |reg_addr[15:3];
  assign d_wide  = |dest_sel[15:1];
  assign b_wide  = |bit_index[15:3];
  assign k8_wide = |literal[15:8];
  assign k9_wide = |literal[15:9];

  assign bit_sel  = 2'(mode - 6'(OP_BCF));
  assign lit_idx  = 4'(mode - 6'(OP_ANDLW));
  assign byte_idx = mode[4:0];

  // Select the word format by opcode
  always_comb begin
    enc.ok   = 1'b1;
    enc.word = W_NOP;
    enc.warn = 1'b0;
    case (mode)
      OP_CLRF: begin
        enc.word = W_CLRF_BASE | {7'b0, reg_addr[4:0]};
        enc.warn = f5_wide;
      end
      OP_CLRW:   enc.word = W_CLRW;
      OP_MOVWF: begin
        enc.word = W_MOVWF_BASE | {7'b0, reg_addr[4:0]};
        enc.warn = f5_wide;
      end
      OP_NOP:    enc.word = W_NOP;
      OP_CLRWDT: enc.word = W_CLRWDT;
      OP_GOTO: begin
        enc.word = W_GOTO_BASE | {3'b0, literal[8:0]};
        enc.warn = k9_wide;
      end
      OP_OPTION: enc.word = W_OPTION;
      OP_SLEEP:  enc.word = W_SLEEP;
      OP_TRIS: begin
        enc.word = {9'b0, reg_addr[2:0]};
        enc.warn = f3_wide;
      end
      default: begin
        if (mode < 6'(OP_BCF)) begin
          // byte-oriented file register operation
          enc.word = {2'b0, BYTE_OPS[byte_idx], dest_sel[0], reg_addr[4:0]};
          enc.warn = d_wide | f5_wide;
        end else if (mode < 6'(OP_ANDLW)) begin
          // bit-oriented file register operation
          enc.word = {BIT_OP_BASE + {2'b0, bit_sel}, bit_index[2:0], reg_addr[4:0]};
          enc.warn = b_wide | f5_wide;
        end else if (mode <= 6'(OP_XORLW)) begin
          // literal operation
          enc.word = {LIT_OPS[lit_idx], literal[7:0]};
          enc.warn = k8_wide;
        end else begin
          // unknown opcode: nothing appended
          enc.ok = 1'b0;
        end
      end
    endcase
  end

endmodule : bpe_encode
`default_nettype wire

// ===== src/bpe_packer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_packer
// Packs 12-bit words MSB-first into bytes, flushes the partial byte on the
// last item and drains the bytes of one item through a three-entry buffer.
// ----------------------------------------------------------------------------
module bpe_packer
  import bpe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_vld,
  input  wire enc_t       enc,
  input  wire logic       item_last,
  output logic            take,
  output logic            out_valid,
  input  wire logic       out_stall,
  output res_t            out_res
);

  logic       half_r, half_nxt;
  logic [3:0] nib_r, nib_nxt;
  logic [1:0] rem_r, rem_nxt;
  res_t       slot_r [SLOTS];
  res_t       slot_nxt [SLOTS];

  logic       fire;
  logic       can_take;
  logic       half_mid;
  logic [3:0] nib_mid;
  logic [1:0] n_emit;
  logic [7:0] e0;
  logic [7:0] e1;
  logic [7:0] flush_byte;
  res_t       gen [SLOTS];

  assign fire      = out_valid && !out_stall;
  assign out_valid = (rem_r != 2'd0);
  assign out_res   = slot_r[0];
  assign can_take  = (rem_r == 2'd0) || ((rem_r == 2'd1) && fire);
  assign take      = item_vld && can_take;

  // Append the word to the pending nibble
  always_comb begin
    e0       = enc.word[11:4];
    e1       = enc.word[7:0];
    half_mid = half_r;
    nib_mid  = nib_r;
    n_emit   = 2'd0;
    if (enc.ok) begin
      if (half_r) begin
        e0       = {nib_r, enc.word[11:8]};
        half_mid = 1'b0;
        nib_mid  = 4'h0;
        n_emit   = 2'd2;
      end else begin
        half_mid = 1'b1;
        nib_mid  = enc.word[3:0];
        n_emit   = 2'd1;
      end
    end
    flush_byte = half_mid ? {nib_mid, 4'h0} : 8'h00;
  end

  // Lay out this item's bytes, flush byte right after the full ones
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      gen[k].data = flush_byte;
      gen[k].warn = enc.warn;
      gen[k].last = 1'b1;
    end
    if (n_emit != 2'd0) begin
      gen[0].data = e0;
      gen[0].last = 1'b0;
    end
    if (n_emit == 2'd2) begin
      gen[1].data = e1;
      gen[1].last = 1'b0;
    end
  end

  // Next state of packer and buffer
  always_comb begin
    half_nxt = half_r;
    nib_nxt  = nib_r;
    rem_nxt  = rem_r;
    for (int k = 0; k < SLOTS; k++) begin
      slot_nxt[k] = slot_r[k];
    end
    if (take) begin
      half_nxt = item_last ? 1'b0 : half_mid;
      nib_nxt  = item_last ? 4'h0 : nib_mid;
      rem_nxt  = n_emit + {1'b0, item_last};
      for (int k = 0; k < SLOTS; k++) begin
        slot_nxt[k] = gen[k];
      end
    end else if (fire) begin
      // advance the buffer by one byte
      rem_nxt     = rem_r - 2'd1;
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
      nib_r  <= 4'h0;
      rem_r  <= 2'd0;
    end else begin
      half_r <= half_nxt;
      nib_r  <= nib_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // Byte buffer
  always_ff @(posedge clk) begin
    for (int k = 0; k < SLOTS; k++) begin
      slot_r[k] <= slot_nxt[k];
    end
  end

  // Checks
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item_last) |=> (!half_r && (nib_r == 4'h0)))
    else $error("packer not empty after flush");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r != 2'd3 || !$past(fire) || $past(take))
    else $error("buffer count grew without a load");

  a_take_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ((rem_r == 2'd0) || (rem_r == 2'd1 && fire)))
    else $error("item loaded over undelivered bytes");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last) |-> (rem_r == 2'd1))
    else $error("final byte is not the last buffered byte");

endmodule : bpe_packer
`default_nettype wire

// ===== src/baseline_pic_instr_encode_pack.sv =====
`default_nettype none
// An accepted item is held in the input register and encoded from it; its
// bytes load into the output buffer when the packer takes the item, which
// waits for the buffer to empty or give its last byte; the first byte is then offered.
// The buffer gives one byte per cycle while out_stall is low; a word gives one
// or two bytes in turn, a last item adds a flush byte and an unknown opcode
// gives no word bytes. A new item enters as the last byte leaves.
// Reset empties the input stage and the byte buffer and clears the pending nibble.
// ----------------------------------------------------------------------------
// baseline_pic_instr_encode_pack
// Baseline PIC 12-bit instruction encoder with MSB-first byte packing.
// ----------------------------------------------------------------------------
module baseline_pic_instr_encode_pack
  import bpe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [5:0]  in_mode,
  input  wire logic [15:0] in_reg_addr,
  input  wire logic [15:0] in_dest_sel,
  input  wire logic [15:0] in_bit_index,
  input  wire logic [15:0] in_literal,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_warn_truncated,
  output logic             out_last_byte
);

  logic        a_vld_r, a_vld_nxt;
  logic [5:0]  mode_r;
  logic [15:0] reg_addr_r;
  logic [15:0] dest_sel_r;
  logic [15:0] bit_index_r;
  logic [15:0] literal_r;
  logic        last_r;
  logic        in_fire;
  logic        take;
  enc_t        enc;
  res_t        res;

  assign in_stall  = a_vld_r && !take;
  assign in_fire   = in_valid && !in_stall;
  assign a_vld_nxt = in_fire ? 1'b1 : (take ? 1'b0 : a_vld_r);

  // Input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r      <= in_mode;
      reg_addr_r  <= in_reg_addr;
      dest_sel_r  <= in_dest_sel;
      bit_index_r <= in_bit_index;
      literal_r   <= in_literal;
      last_r      <= in_last_item;
    end
  end

  bpe_encode u_encode (
    .mode      (mode_r),
    .reg_addr  (reg_addr_r),
    .dest_sel  (dest_sel_r),
    .bit_index (bit_index_r),
    .literal   (literal_r),
    .enc       (enc)
  );

  bpe_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (a_vld_r),
    .enc       (enc),
    .item_last (last_r),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_byte           = res.data;
  assign out_warn_truncated = res.warn;
  assign out_last_byte      = res.last;

endmodule : baseline_pic_instr_encode_pack
`default_nettype wire
